>>> rtl/wfac_pkg.sv
// Shared types, constants and register map of the frame airtime calculator.
package wfac_pkg;

  localparam int NUM_W = 29;
  localparam int DEN_W = 20;
  localparam int OFS_W = 11;
  localparam int SYM_W = 4;
  localparam int AIR_W = 16;
  localparam int BPS_W = 14;
  localparam int ADDR_W = 5;

  localparam logic [18:0] RECIP_1000 = 19'd268435;
  localparam int RECIP_SHIFT = 28;
  localparam logic [12:0] BITS_KBPS = 13'd8000;
  localparam logic [AIR_W-1:0] AIR_MAX = '1;

  localparam logic [2:0] REG_CCK_SIFS = 3'd0;
  localparam logic [2:0] REG_CCK_PRE = 3'd1;
  localparam logic [2:0] REG_CCK_PLCP = 3'd2;
  localparam logic [2:0] REG_OFDM_SIFS = 3'd3;
  localparam logic [2:0] REG_OFDM_PRE = 3'd4;
  localparam logic [2:0] REG_OFDM_PLCP = 3'd5;
  localparam logic [2:0] REG_OFDM_SYM = 3'd6;

  localparam logic [1:0] PHY_CCK = 2'd0;
  localparam logic [1:0] PHY_OFDM = 2'd1;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_CCK,
    CLS_OFDM
  } cls_t;

  typedef struct packed {
    logic [7:0] cck_sifs;
    logic [9:0] cck_pre;
    logic [7:0] cck_plcp;
    logic [7:0] ofdm_sifs;
    logic [7:0] ofdm_pre;
    logic [7:0] ofdm_plcp;
    logic [SYM_W-1:0] ofdm_sym;
  } cfg_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [OFS_W-1:0] ofs;
    logic [SYM_W-1:0] mul;
    logic zero;
    logic err;
  } job_t;

endpackage

>>> rtl/wfac_front.sv
// Front end: accept requests, classify them and prepare divider operands.
module wfac_front (
  input  logic clk,
  input  logic rst,
  input  wfac_pkg::cfg_t cfg,
  input  logic start,
  input  logic [1:0] phy_kind,
  input  logic [19:0] rate_kbps,
  input  logic [15:0] frame_len,
  input  logic short_preamble_req,
  input  logic rate_allows_short,
  output logic push,
  output wfac_pkg::job_t job
);
  import wfac_pkg::*;

  logic v1, v2;
  cls_t cls1, cls2;
  logic [NUM_W-1:0] lenx1, lenx2;
  logic [DEN_W-1:0] kbps1, kbps2;
  logic [19:0] bits1, bits2;
  logic [OFS_W-1:0] ofs1, ofs2;
  logic [23:0] x1, x2;
  logic [BPS_W-1:0] q2;
  logic [10:0] phy_sum;
  logic [42:0] prod;
  logic [23:0] qk, rem;
  logic [BPS_W-1:0] bps;
  cls_t cls_next;

  always_comb begin
    phy_sum = 11'(cfg.cck_pre) + 11'(cfg.cck_plcp);
    if (short_preamble_req && rate_allows_short) begin
      phy_sum = phy_sum >> 1;
    end
    if (rate_kbps == '0) begin
      cls_next = CLS_NONE;
    end else if (phy_kind == PHY_CCK) begin
      cls_next = CLS_CCK;
    end else if (phy_kind == PHY_OFDM) begin
      cls_next = CLS_OFDM;
    end else begin
      cls_next = CLS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    cls1 <= cls_next;
    kbps1 <= rate_kbps;
    lenx1 <= NUM_W'(frame_len) * NUM_W'(BITS_KBPS);
    bits1 <= 20'(frame_len) * 20'd8 + 20'(cfg.ofdm_plcp);
    x1 <= 24'(rate_kbps) * 24'(cfg.ofdm_sym);
    if (cls_next == CLS_CCK) begin
      ofs1 <= OFS_W'(cfg.cck_sifs) + phy_sum;
    end else begin
      ofs1 <= OFS_W'(cfg.ofdm_sifs) + OFS_W'(cfg.ofdm_pre);
    end
    cls2 <= cls1;
    kbps2 <= kbps1;
    lenx2 <= lenx1;
    bits2 <= bits1;
    ofs2 <= ofs1;
    x2 <= x1;
    q2 <= prod[RECIP_SHIFT +: BPS_W];
  end

  assign prod = 43'(x1) * 43'(RECIP_1000);

  always_comb begin
    qk = 24'(q2) * 24'd1000;
    rem = x2 - qk;
    bps = (rem >= 24'd1000) ? q2 + 1'b1 : q2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= v2;
    end
  end

  always_ff @(posedge clk) begin
    job.ofs <= ofs2;
    job.zero <= 1'b0;
    job.err <= 1'b0;
    case (cls2)
      CLS_CCK: begin
        job.num <= lenx2;
        job.den <= kbps2;
        job.mul <= SYM_W'(1);
      end
      CLS_OFDM: begin
        job.mul <= cfg.ofdm_sym;
        if (bps == '0) begin
          job.num <= '0;
          job.den <= DEN_W'(1);
          job.zero <= 1'b1;
          job.err <= 1'b1;
        end else begin
          job.num <= NUM_W'(bits2) + NUM_W'(bps) - NUM_W'(1);
          job.den <= DEN_W'(bps);
        end
      end
      default: begin
        job.num <= '0;
        job.den <= DEN_W'(1);
        job.mul <= '0;
        job.zero <= 1'b1;
      end
    endcase
  end

endmodule

>>> rtl/wfac_queue.sv
// Two-entry request queue between front end and back end.
module wfac_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  wfac_pkg::job_t din,
  input  logic pop_rdy,
  output logic out_vld,
  output wfac_pkg::job_t dout,
  output logic full
);
  import wfac_pkg::*;

  job_t ent [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic pop;

  assign out_vld = (count != 2'd0);
  assign full = (count == 2'd2);
  assign pop = out_vld && pop_rdy;
  assign dout = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= din;
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(full && push && !pop))
    else $error("queue overflow");

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");

  assert property (@(posedge clk) disable iff (rst) (push && !pop) |=> out_vld)
    else $error("pushed request not visible");

endmodule

>>> rtl/wfac_back.sv
// Back end: pipelined divider, symbol scaling and saturating sum.
module wfac_back (
  input  logic clk,
  input  logic rst,
  input  logic in_vld,
  input  wfac_pkg::job_t job,
  output logic rdy,
  output logic done,
  output logic [15:0] airtime_us,
  output logic rate_error
);
  import wfac_pkg::*;

  typedef struct packed {
    logic vld;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] quo;
    logic [OFS_W-1:0] ofs;
    logic [SYM_W-1:0] mul;
    logic zero;
    logic err;
  } stg_t;

  stg_t stg [NUM_W+1];
  logic a_vld, a_zero, a_err;
  logic [NUM_W+SYM_W-1:0] a_prod;
  logic [OFS_W-1:0] a_ofs;
  logic [NUM_W+SYM_W:0] sum;

  assign rdy = 1'b1;

  always_comb begin
    stg[0].vld = in_vld;
    stg[0].num = job.num;
    stg[0].den = job.den;
    stg[0].rem = '0;
    stg[0].quo = '0;
    stg[0].ofs = job.ofs;
    stg[0].mul = job.mul;
    stg[0].zero = job.zero;
    stg[0].err = job.err;
  end

  for (genvar s = 1; s <= NUM_W; s++) begin : g_div
    logic [DEN_W:0] trial;
    logic ge;
    assign trial = {stg[s-1].rem, stg[s-1].num[NUM_W-1]};
    assign ge = (trial >= {1'b0, stg[s-1].den});

    always_ff @(posedge clk) begin
      if (rst) begin
        stg[s].vld <= 1'b0;
      end else begin
        stg[s].vld <= stg[s-1].vld;
      end
      stg[s].num <= stg[s-1].num << 1;
      stg[s].den <= stg[s-1].den;
      stg[s].rem <= ge ? DEN_W'(trial - {1'b0, stg[s-1].den}) : trial[DEN_W-1:0];
      stg[s].quo <= {stg[s-1].quo[NUM_W-2:0], ge};
      stg[s].ofs <= stg[s-1].ofs;
      stg[s].mul <= stg[s-1].mul;
      stg[s].zero <= stg[s-1].zero;
      stg[s].err <= stg[s-1].err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      done <= 1'b0;
    end else begin
      a_vld <= stg[NUM_W].vld;
      done <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_prod <= (NUM_W+SYM_W)'(stg[NUM_W].quo) * (NUM_W+SYM_W)'(stg[NUM_W].mul);
    a_ofs <= stg[NUM_W].ofs;
    a_zero <= stg[NUM_W].zero;
    a_err <= stg[NUM_W].err;
  end

  assign sum = (NUM_W+SYM_W+1)'(a_prod) + (NUM_W+SYM_W+1)'(a_ofs);

  always_ff @(posedge clk) begin
    rate_error <= a_err;
    if (a_zero) begin
      airtime_us <= '0;
    end else if (sum > (NUM_W+SYM_W+1)'(AIR_MAX)) begin
      airtime_us <= AIR_MAX;
    end else begin
      airtime_us <= sum[AIR_W-1:0];
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    stg[NUM_W].vld |-> (stg[NUM_W].rem < stg[NUM_W].den))
    else $error("divider remainder not below divisor");

  assert property (@(posedge clk) disable iff (rst)
    done && rate_error |-> airtime_us == '0)
    else $error("rate error with nonzero airtime");

  assert property (@(posedge clk) disable iff (rst)
    stg[NUM_W].vld |-> stg[NUM_W].den != '0)
    else $error("zero divisor reached divider output");

endmodule

>>> rtl/wlan_frame_airtime_calc.sv
// Top level of the 802.11 frame airtime calculator.
//
// Requests enter on start with phy_kind, rate_kbps, frame_len,
// short_preamble_req and rate_allows_short; busy never rises in normal use,
// so one request may be taken every clock cycle.
// Each request yields exactly one result: done pulses for one cycle with
// airtime_us (saturated at 65535) and rate_error. Results leave in request
// order.
// From start to done a request passes three front-end stages, one queue
// stage, a 29-stage restoring divider (one quotient bit per stage),
// a symbol scaling stage and a saturating add stage.
// Throughput is one request per cycle.
// Timing constants sit in seven APB registers at byte offsets 0 to 24;
// write them only while no request is in flight.
// Reset (synchronous, active high) restores the default timing values and
// empties the pipeline. The receiver cannot stall; done is never held.
module wlan_frame_airtime_calc (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic start,
  output logic busy,
  input  logic [1:0] phy_kind,
  input  logic [19:0] rate_kbps,
  input  logic [15:0] frame_len,
  input  logic short_preamble_req,
  input  logic rate_allows_short,
  output logic done,
  output logic [15:0] airtime_us,
  output logic rate_error
);
  import wfac_pkg::*;

  cfg_t cfg;
  logic [2:0] idx;
  logic wr_en, push, q_vld, q_full, back_rdy;
  job_t f_job, q_job;

  assign pready = 1'b1;
  assign idx = paddr[4:2];
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cck_sifs <= 8'd10;
      cfg.cck_pre <= 10'd144;
      cfg.cck_plcp <= 8'd48;
      cfg.ofdm_sifs <= 8'd16;
      cfg.ofdm_pre <= 8'd20;
      cfg.ofdm_plcp <= 8'd22;
      cfg.ofdm_sym <= 4'd4;
    end else if (wr_en) begin
      case (idx)
        REG_CCK_SIFS: cfg.cck_sifs <= pwdata[7:0];
        REG_CCK_PRE: cfg.cck_pre <= pwdata[9:0];
        REG_CCK_PLCP: cfg.cck_plcp <= pwdata[7:0];
        REG_OFDM_SIFS: cfg.ofdm_sifs <= pwdata[7:0];
        REG_OFDM_PRE: cfg.ofdm_pre <= pwdata[7:0];
        REG_OFDM_PLCP: cfg.ofdm_plcp <= pwdata[7:0];
        REG_OFDM_SYM: cfg.ofdm_sym <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CCK_SIFS: prdata = 32'(cfg.cck_sifs);
      REG_CCK_PRE: prdata = 32'(cfg.cck_pre);
      REG_CCK_PLCP: prdata = 32'(cfg.cck_plcp);
      REG_OFDM_SIFS: prdata = 32'(cfg.ofdm_sifs);
      REG_OFDM_PRE: prdata = 32'(cfg.ofdm_pre);
      REG_OFDM_PLCP: prdata = 32'(cfg.ofdm_plcp);
      REG_OFDM_SYM: prdata = 32'(cfg.ofdm_sym);
      default: prdata = '0;
    endcase
  end

  assign busy = q_full;

  wfac_front u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .start(start && !busy),
    .phy_kind(phy_kind),
    .rate_kbps(rate_kbps),
    .frame_len(frame_len),
    .short_preamble_req(short_preamble_req),
    .rate_allows_short(rate_allows_short),
    .push(push),
    .job(f_job)
  );

  wfac_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .din(f_job),
    .pop_rdy(back_rdy),
    .out_vld(q_vld),
    .dout(q_job),
    .full(q_full)
  );

  wfac_back u_back (
    .clk(clk),
    .rst(rst),
    .in_vld(q_vld),
    .job(q_job),
    .rdy(back_rdy),
    .done(done),
    .airtime_us(airtime_us),
    .rate_error(rate_error)
  );

endmodule
